FILE: rtl/cirt_pkg.sv
package cirt_pkg;

    // table geometry and field widths
    localparam int NUM_TYPES   = 64;
    localparam int NET_ID_BITS = 16;
    localparam int TYPE_W      = 6;
    localparam int TBL_DEPTH   = 64;
    localparam int IDX_W       = $clog2(TBL_DEPTH);

    // code returned by a failed net-to-host lookup
    localparam logic [TYPE_W-1:0] NO_CMD_CODE = TYPE_W'(0);

    // operation codes
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_N2H = 2'd1;
    localparam logic [1:0] OP_H2N = 2'd2;

    // command transfer
    typedef struct packed {
        logic [1:0]             operation;
        logic [TYPE_W-1:0]      type_in;
        logic [NET_ID_BITS-1:0] net_id_in;
    } t_cmd;

    // result transfer
    typedef struct packed {
        logic                   ok;
        logic [TYPE_W-1:0]      type_out;
        logic [NET_ID_BITS-1:0] net_id_out;
    } t_rsp;

    // sequencer to reverse table
    typedef struct packed {
        logic [IDX_W-1:0]       rd_addr;
        logic [NET_ID_BITS-1:0] cmp_key;
        logic                   wr_en;
        logic [IDX_W-1:0]       wr_addr;
        logic [NET_ID_BITS-1:0] wr_key;
        logic [TYPE_W-1:0]      wr_type;
        logic                   clr_en;
        logic [IDX_W-1:0]       clr_addr;
    } t_rev_ctl;

    // reverse table compare result for the entry read last cycle
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              hit;
        logic              free;
        logic [TYPE_W-1:0] rtype;
    } t_rev_stat;

endpackage

FILE: rtl/cirt_rev_table.sv
module cirt_rev_table
    import cirt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rev_ctl  i_ctl,
    output t_rev_stat o_stat
);

    logic [NET_ID_BITS-1:0] r_key_mem  [TBL_DEPTH];
    logic [TYPE_W-1:0]      r_type_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0]   r_valid;
    logic [NET_ID_BITS-1:0] r_key_q;
    logic [TYPE_W-1:0]      r_type_q;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [NET_ID_BITS-1:0] r_cmp_q;

    // key and type storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_key_mem[i_ctl.wr_addr]  <= i_ctl.wr_key;
            r_type_mem[i_ctl.wr_addr] <= i_ctl.wr_type;
        end
        r_key_q  <= r_key_mem[i_ctl.rd_addr];
        r_type_q <= r_type_mem[i_ctl.rd_addr];
        r_rd_idx <= i_ctl.rd_addr;
        r_cmp_q  <= i_ctl.cmp_key;
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_addr] <= 1'b1;
        end else if (i_ctl.clr_en) begin
            r_valid[i_ctl.clr_addr] <= 1'b0;
        end
    end

    // shared key comparator
    always_comb begin
        o_stat.idx   = r_rd_idx;
        o_stat.hit   = r_valid[r_rd_idx] && (r_key_q == r_cmp_q);
        o_stat.free  = !r_valid[r_rd_idx];
        o_stat.rtype = r_type_q;
    end

endmodule

FILE: rtl/command_id_remap_table.sv
// Two-way remap between host command types and network command ids. A command is
// taken when start is high and busy is low; its single result appears on o_rsp for
// one cycle with o_rsp_valid high and must be captured then, as it cannot be held
// off. A type-to-net lookup reads the forward table as the command is taken and
// registers its result in the S_FWD state. A net-to-type lookup searches the
// 64-entry reverse table through one key comparator, one entry per cycle. A set that
// replaces an existing mapping searches the reverse table twice and then writes, but
// fails without writing if the first search misses the old entry. busy is low again
// while the result is shown, so the next command may be given in that cycle.
module command_id_remap_table
    import cirt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_SCAN,
        S_WRITE
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [NET_ID_BITS-1:0] r_key, n_key;
    logic                   r_second, n_second;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [IDX_W-1:0]       r_free, n_free;
    logic                   r_free_found, n_free_found;
    logic                   r_rsp_valid, n_rsp_valid;
    t_rsp                   r_rsp, n_rsp;

    logic [NET_ID_BITS-1:0] r_fwd_mem [TBL_DEPTH];
    logic [NET_ID_BITS-1:0] r_fwd_q;
    logic [TBL_DEPTH-1:0]   r_fwd_vld;
    logic                   fwd_we;
    logic                   fwd_hit;
    logic                   last;
    logic [IDX_W-1:0]       free_now;

    t_rev_ctl  rev_ctl;
    t_rev_stat rev_stat;

    cirt_rev_table u_rev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rev_ctl),
        .o_stat  (rev_stat)
    );

    // forward table, read at the command's type on every transfer
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[r_cmd.type_in] <= r_cmd.net_id_in;
        end
        r_fwd_q <= r_fwd_mem[i_cmd.type_in];
    end

    // forward valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= '0;
        end else if (fwd_we) begin
            r_fwd_vld[r_cmd.type_in] <= 1'b1;
        end
    end

    assign fwd_hit  = r_fwd_vld[r_cmd.type_in];
    assign last     = (rev_stat.idx == IDX_W'(TBL_DEPTH - 1));
    assign free_now = r_free_found ? r_free : (rev_stat.free ? rev_stat.idx : '0);

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_second     = r_second;
        n_slot       = r_slot;
        n_free       = r_free;
        n_free_found = r_free_found;
        n_rsp_valid  = 1'b0;
        n_rsp        = r_rsp;
        fwd_we       = 1'b0;

        rev_ctl.rd_addr  = rev_stat.idx + IDX_W'(1);
        rev_ctl.wr_en    = 1'b0;
        rev_ctl.wr_addr  = r_slot;
        rev_ctl.wr_key   = r_cmd.net_id_in;
        rev_ctl.wr_type  = r_cmd.type_in;
        rev_ctl.clr_en   = 1'b0;
        rev_ctl.clr_addr = rev_stat.idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_FWD;
                end
            end

            S_FWD: begin
                case (r_cmd.operation)
                    OP_SET: begin
                        rev_ctl.rd_addr = '0;
                        n_free_found    = 1'b0;
                        n_free          = '0;
                        n_second        = !fwd_hit;
                        n_key           = fwd_hit ? r_fwd_q : r_cmd.net_id_in;
                        n_state         = S_SCAN;
                    end
                    OP_N2H: begin
                        rev_ctl.rd_addr = '0;
                        n_key           = r_cmd.net_id_in;
                        n_state         = S_SCAN;
                    end
                    OP_H2N: begin
                        n_rsp_valid      = 1'b1;
                        n_rsp.ok         = 1'b1;
                        n_rsp.type_out   = '0;
                        n_rsp.net_id_out = fwd_hit ? r_fwd_q
                                                   : NET_ID_BITS'(r_cmd.type_in);
                        n_state          = S_IDLE;
                    end
                    default: begin
                        n_rsp_valid = 1'b1;
                        n_rsp       = '0;
                        n_state     = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                if (r_cmd.operation == OP_SET && !r_second) begin
                    // search for the entry under the old net id and erase it
                    if (rev_stat.hit) begin
                        rev_ctl.clr_en  = 1'b1;
                        rev_ctl.rd_addr = '0;
                        n_second        = 1'b1;
                        n_key           = r_cmd.net_id_in;
                    end else if (last) begin
                        n_rsp_valid = 1'b1;
                        n_rsp       = '0;
                        n_state     = S_IDLE;
                    end
                end else if (r_cmd.operation == OP_SET) begin
                    // search for the new net id, noting the lowest free slot
                    if (rev_stat.free && !r_free_found) begin
                        n_free       = rev_stat.idx;
                        n_free_found = 1'b1;
                    end
                    if (rev_stat.hit) begin
                        n_slot  = rev_stat.idx;
                        n_state = S_WRITE;
                    end else if (last) begin
                        n_slot  = free_now;
                        n_state = S_WRITE;
                    end
                end else begin
                    // net-to-host lookup with identity fallback for small ids
                    if (rev_stat.hit) begin
                        n_rsp_valid      = 1'b1;
                        n_rsp.ok         = 1'b1;
                        n_rsp.type_out   = rev_stat.rtype;
                        n_rsp.net_id_out = '0;
                        n_state          = S_IDLE;
                    end else if (last) begin
                        n_rsp_valid      = 1'b1;
                        n_rsp.net_id_out = '0;
                        if (r_cmd.net_id_in < NET_ID_BITS'(NUM_TYPES - 1)) begin
                            n_rsp.ok       = 1'b1;
                            n_rsp.type_out = r_cmd.net_id_in[TYPE_W-1:0];
                        end else begin
                            n_rsp.ok       = 1'b0;
                            n_rsp.type_out = NO_CMD_CODE;
                        end
                        n_state = S_IDLE;
                    end
                end
            end

            S_WRITE: begin
                fwd_we        = 1'b1;
                rev_ctl.wr_en = 1'b1;
                n_rsp_valid   = 1'b1;
                n_rsp         = '0;
                n_rsp.ok      = 1'b1;
                n_state       = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the compare key is captured together with the read address
        rev_ctl.cmp_key = n_key;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_second     <= 1'b0;
            r_free_found <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_second     <= n_second;
            r_free_found <= n_free_found;
            r_rsp_valid  <= n_rsp_valid;
        end
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_slot <= n_slot;
        r_free <= n_free;
        r_rsp  <= n_rsp;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/cirt_checker.sv
module cirt_checker
    import cirt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp
);

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_rsp_valid))
        else $error("block not idle after reset");

    // an accepted command always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    // results come only once the block is free again
    a_rsp_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !busy)
        else $error("result shown while busy");

    // no two results in consecutive cycles
    a_rsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("result strobe held for two cycles");

    // a failed operation carries no net id
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.ok) |-> (o_rsp.net_id_out == '0))
        else $error("failed result carries a net id");

endmodule

bind command_id_remap_table cirt_checker u_cirt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

FILE: tb/remap_check.sv
module remap_check
    import cirt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    input  logic i_busy,
    input  logic i_rsp_valid,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_not_ok
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the forward and reverse tables
    logic                   fwd_valid [TBL_DEPTH];
    logic [NET_ID_BITS-1:0] fwd_net   [TBL_DEPTH];
    logic                   rev_valid [TBL_DEPTH];
    logic [NET_ID_BITS-1:0] rev_key   [TBL_DEPTH];
    logic [TYPE_W-1:0]      rev_type  [TBL_DEPTH];

    // results still owed by the block, oldest first
    t_rsp owed_rsp[$];
    int   error_count;
    int   checked_count;
    int   not_ok_count;

    // slot of the live reverse entry holding this key, or -1
    function automatic int rev_slot(input logic [NET_ID_BITS-1:0] key);
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (rev_valid[i] && rev_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // apply one command to the shadow tables and work out its result
    function automatic t_rsp remap_step(input t_cmd c);
        t_rsp r;
        int   slot;
        r = '0;
        case (c.operation)
            OP_SET: begin
                // a remapped type drops the reverse entry under its old id
                if (fwd_valid[c.type_in]) begin
                    slot = rev_slot(fwd_net[c.type_in]);
                    if (slot < 0) begin
                        return r;
                    end
                    rev_valid[slot] = 1'b0;
                end
                fwd_valid[c.type_in] = 1'b1;
                fwd_net[c.type_in]   = c.net_id_in;
                // overwrite a matching key, else take the lowest free slot
                slot = rev_slot(c.net_id_in);
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (!rev_valid[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                rev_valid[slot] = 1'b1;
                rev_key[slot]   = c.net_id_in;
                rev_type[slot]  = c.type_in;
                r.ok = 1'b1;
            end
            OP_N2H: begin
                slot = rev_slot(c.net_id_in);
                if (slot >= 0) begin
                    r.type_out = rev_type[slot];
                    r.ok       = 1'b1;
                end else if (int'(c.net_id_in) < NUM_TYPES - 1) begin
                    // identity fallback for small ids
                    r.type_out = c.net_id_in[TYPE_W-1:0];
                    r.ok       = 1'b1;
                end else begin
                    r.type_out = NO_CMD_CODE;
                end
            end
            OP_H2N: begin
                r.net_id_out = fwd_valid[c.type_in] ? fwd_net[c.type_in]
                                                    : NET_ID_BITS'(c.type_in);
                r.ok         = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // watch both channels, results first so a same-edge command queues behind
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                fwd_valid[i] = 1'b0;
                fwd_net[i]   = '0;
                rev_valid[i] = 1'b0;
                rev_key[i]   = '0;
                rev_type[i]  = '0;
            end
            owed_rsp.delete();
            error_count   = 0;
            checked_count = 0;
            not_ok_count  = 0;
        end else begin
            if (i_rsp_valid) begin
                if (owed_rsp.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: result with none owed: ok %0b type %0d net %0d",
                                 $realtime, i_rsp.ok, i_rsp.type_out, i_rsp.net_id_out);
                    end
                end else begin
                    want = owed_rsp.pop_front();
                    checked_count++;
                    if (i_rsp.ok !== want.ok || i_rsp.type_out !== want.type_out
                            || i_rsp.net_id_out !== want.net_id_out) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch: ok %0b/%0b type %0d/%0d net %0d/%0d",
                                     $realtime, want.ok, i_rsp.ok, want.type_out,
                                     i_rsp.type_out, want.net_id_out, i_rsp.net_id_out);
                            $display("    (values shown as predicted/seen)");
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                want = remap_step(i_cmd);
                if (!want.ok) begin
                    not_ok_count++;
                end
                owed_rsp.push_back(want);
            end
        end
        o_errors  <= error_count;
        o_pending <= owed_rsp.size();
        o_checked <= checked_count;
        o_not_ok  <= not_ok_count;
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cirt_pkg::*;

    localparam int         RANDOM_ITEMS = 1800;
    localparam int         QUIET_TAIL   = 300;
    localparam int         DRAIN_EVERY  = 600;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         TAIL_CYCLES  = 8;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_rsp_valid;
    t_rsp o_rsp;

    int errors;
    int pending;
    int checked;
    int not_ok;
    int cycle_count = 0;
    int sent_per_op [4];
    bit timed_out = 1'b0;

    // a handful of ids reused so that types collide on the same net id
    logic [NET_ID_BITS-1:0] net_pool [16];

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    command_id_remap_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    remap_check u_remap_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_busy      (busy),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp       (o_rsp),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_not_ok    (not_ok)
    );

    // hold a command until the block takes it
    task automatic issue(input logic [1:0] op, input logic [TYPE_W-1:0] ty,
                         input logic [NET_ID_BITS-1:0] net);
        t_cmd c;
        c.operation = op;
        c.type_in   = ty;
        c.net_id_in = net;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sent_per_op[int'(op)]++;
    endtask

    // sender gap with junk on the command bus
    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) begin
            i_cmd <= t_cmd'($urandom);
            @(posedge i_clk);
        end
    endtask

    // stop sending until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return OP_SET;
        if (r < 70) return OP_N2H;
        if (r < 98) return OP_H2N;
        return OP_UNUSED;
    endfunction

    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(1) == 0) return TYPE_W'($urandom_range(7));
        return TYPE_W'($urandom_range(NUM_TYPES - 1));
    endfunction

    // mostly ids near the identity boundary or from the shared pool
    function automatic logic [NET_ID_BITS-1:0] pick_net();
        int r;
        r = $urandom_range(99);
        if (r < 45) return NET_ID_BITS'($urandom_range(127));
        if (r < 80) return net_pool[$urandom_range(15)];
        return NET_ID_BITS'($urandom);
    endfunction

    initial begin
        foreach (net_pool[k]) begin
            net_pool[k] = NET_ID_BITS'($urandom);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                // identity fallbacks and the id boundary on an empty table
                issue(OP_H2N, 6'd0, 16'd0);
                issue(OP_H2N, 6'd63, 16'hffff);
                issue(OP_N2H, 6'd0, 16'd0);
                issue(OP_N2H, 6'd63, 16'd62);
                issue(OP_N2H, 6'd0, 16'd63);
                issue(OP_N2H, 6'd0, 16'hffff);
                // two types on one id, then the stale reverse entry is lost
                issue(OP_SET, 6'd5, 16'd1000);
                issue(OP_H2N, 6'd5, 16'd0);
                issue(OP_N2H, 6'd0, 16'd1000);
                issue(OP_SET, 6'd6, 16'd1000);
                issue(OP_N2H, 6'd0, 16'd1000);
                issue(OP_SET, 6'd5, 16'd2000);
                issue(OP_N2H, 6'd0, 16'd1000);
                issue(OP_SET, 6'd6, 16'd3000);
                issue(OP_H2N, 6'd6, 16'd0);
                // field extremes and a mapping that overrides identity
                issue(OP_SET, 6'd63, 16'hffff);
                issue(OP_N2H, 6'd0, 16'hffff);
                issue(OP_SET, 6'd0, 16'd0);
                issue(OP_N2H, 6'd63, 16'd0);
                issue(OP_SET, 6'd1, 16'd40);
                issue(OP_N2H, 6'd0, 16'd40);
                issue(OP_H2N, 6'd63, 16'd0);
                issue(OP_UNUSED, 6'd63, 16'hffff);
                issue(OP_SET, 6'd63, 16'd63);
                issue(OP_N2H, 6'd0, 16'hffff);
                issue(OP_N2H, 6'd0, 16'd63);
                drain();

                // random traffic, quiet towards the end
                for (int n = 0; n < RANDOM_ITEMS; n++) begin
                    issue(pick_op(), pick_type(), pick_net());
                    if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
                        drain();
                    end else if (n < RANDOM_ITEMS - QUIET_TAIL
                                 && $urandom_range(3) == 0) begin
                        idle($urandom_range(1, 4));
                    end
                end
                drain();
                repeat (TAIL_CYCLES) @(posedge i_clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
                timed_out = 1'b1;
            end
        join_any

        $display("covered %0d sets, %0d net-to-type, %0d type-to-net, %0d unused-code transfers",
                 sent_per_op[0], sent_per_op[1], sent_per_op[2], sent_per_op[3]);
        $display("%0d results compared, %0d answered not ok, %0d mismatches, timeout %0b",
                 checked, not_ok, errors, timed_out);
        if (!timed_out && errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cirt_pkg.sv
rtl/cirt_rev_table.sv
rtl/command_id_remap_table.sv
rtl/cirt_checker.sv
tb/remap_check.sv
tb/testbench.sv
